// ===== design/lgp_pkg.sv =====
`default_nettype none
package lgp_pkg;
	localparam int MAX_GRID   = 32;
	localparam int GRID_BITS  = $clog2(MAX_GRID);
	localparam int ADDR_BITS  = 2 * GRID_BITS;
	localparam int VALUE_BITS = 16;
	localparam int SUM_BITS   = 23;
	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	localparam logic REG_GRID_SIZE = 1'b0;
	localparam logic REG_LOOKAHEAD = 1'b1;

	typedef struct packed {
		logic                 start;
		logic [GRID_BITS-1:0] sr;
		logic [GRID_BITS-1:0] sc;
		logic [GRID_BITS-1:0] ext;
		logic [GRID_BITS-1:0] lim;
	} score_req_t;

	typedef struct packed {
		logic                done;
		logic [SUM_BITS-1:0] best;
	} score_rsp_t;

	function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
			input logic [VALUE_BITS-1:0] b);
		logic [SUM_BITS:0] s;
		s = {1'b0, a} + {{(SUM_BITS + 1 - VALUE_BITS){1'b0}}, b};
		sat_add = s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== design/lgp_ram.sv =====
`default_nettype none
module lgp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/lgp_score.sv =====
`default_nettype none
module lgp_score (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lgp_pkg::score_req_t                 req,
	output lgp_pkg::score_rsp_t                      rsp,
	output logic      [lgp_pkg::ADDR_BITS-1:0]       rd_addr,
	input  wire logic [lgp_pkg::VALUE_BITS-1:0]      rd_data
);
	import lgp_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_ADDR, S_CALC} state_t;

	state_t               state_q;
	logic [GRID_BITS-1:0] ii_q, jj_q, sr_q, sc_q, ext_q, lim_q;
	logic                 zero_q;
	logic [SUM_BITS-1:0]  left_q, best_q;
	logic [SUM_BITS-1:0]  line_q [MAX_GRID];
	logic                 done_q;

	logic [GRID_BITS-1:0]  row_c, col_c;
	logic [GRID_BITS:0]    diag_c;
	logic [SUM_BITS-1:0]   up_c, lf_c, base_c, sum_c;
	logic [VALUE_BITS-1:0] v_c;

	assign row_c   = sr_q + ii_q;
	assign col_c   = sc_q + jj_q;
	assign diag_c  = {1'b0, row_c} + {1'b0, col_c};
	assign rd_addr = {row_c, col_c};

	// dp over the window, one cell per pass through the shared adder
	assign v_c    = zero_q ? '0 : rd_data;
	assign up_c   = (ii_q == '0) ? '0 : line_q[jj_q];
	assign lf_c   = (jj_q == '0) ? '0 : left_q;
	assign base_c = (up_c > lf_c) ? up_c : lf_c;
	assign sum_c  = sat_add(base_c, v_c);

	assign rsp.done = done_q;
	assign rsp.best = best_q;

	always_ff @(posedge clk) begin
		if (state_q == S_CALC) begin
			line_q[jj_q] <= sum_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			ii_q    <= '0;
			jj_q    <= '0;
			sr_q    <= '0;
			sc_q    <= '0;
			ext_q   <= '0;
			lim_q   <= '0;
			zero_q  <= 1'b0;
			left_q  <= '0;
			best_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						sr_q    <= req.sr;
						sc_q    <= req.sc;
						ext_q   <= req.ext;
						lim_q   <= req.lim;
						ii_q    <= '0;
						jj_q    <= '0;
						best_q  <= '0;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					zero_q  <= diag_c > {1'b0, lim_q};
					state_q <= S_CALC;
				end
				S_CALC: begin
					left_q <= sum_c;
					if (sum_c > best_q) begin
						best_q <= sum_c;
					end
					if (jj_q == ext_q) begin
						jj_q <= '0;
						if (ii_q == ext_q) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							ii_q    <= ii_q + 1'b1;
							state_q <= S_ADDR;
						end
					end else begin
						jj_q    <= jj_q + 1'b1;
						state_q <= S_ADDR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE) else $error("done outside idle");
	a_ext_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADDR) |-> ({1'b0, ii_q} <= {1'b0, ext_q} && jj_q <= ext_q))
		else $error("window index past extent");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.start) else $error("start while busy");
endmodule
`default_nettype wire

// ===== design/lookahead_greedy_grid_path.sv =====
`default_nettype none
// Greedy walk over a triangular grid with windowed max-path lookahead. A load item (opcode 0)
// writes one cell; cells outside the 32x32 store are dropped. A run item (opcode 1) raises
// in_stall until its closing record is in the output register: each move scores the right
// and the down candidate in turn on one shared window unit, which reads each window cell through
// the single grid memory read port; the window extent is clipped by the diagonal. Every cell a run
// touches must have been loaded since reset.
module lookahead_greedy_grid_path (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [6:0]                        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [5:0]                        cell_row,
	input  wire logic [5:0]                        cell_col,
	input  wire logic [15:0]                       cell_value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   is_step,
	output logic [5:0]                             step_row,
	output logic [5:0]                             step_col,
	output logic [22:0]                            running_total,
	output logic                                   last
);
	import lgp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_INIT_ADD, ST_CHECK, ST_WAIT_R, ST_WAIT_D,
		ST_MOVE, ST_FETCH, ST_ADD, ST_EMIT, ST_EMIT_LAST
	} state_t;

	state_t               state_q;
	logic [6:0]           grid_size_q, lookahead_q;
	logic [GRID_BITS-1:0] lim_q, r_q, c_q;
	logic [6:0]           la_m1_q;
	logic [SUM_BITS-1:0]  total_q, right_q;
	score_req_t           req_q;
	score_rsp_t           rsp;

	logic [ADDR_BITS-1:0]  score_addr, ram_raddr;
	logic [VALUE_BITS-1:0] ram_rdata;
	logic                  load_c, out_free, emit_c;
	logic [GRID_BITS-1:0]  lim_c, ext_r_c, ext_d_c, d_r_c, d_d_c;
	logic [6:0]            gs_eff_c;

	assign in_stall = state_q != ST_IDLE;
	assign load_c   = in_valid && !in_stall && opcode == OP_LOAD &&
		{1'b0, cell_row} < 7'(MAX_GRID) && {1'b0, cell_col} < 7'(MAX_GRID);
	assign out_free = !out_valid || !out_stall;
	assign emit_c   = (state_q == ST_EMIT || state_q == ST_EMIT_LAST) && out_free;

	assign gs_eff_c = (grid_size_q == '0) ? 7'd1 :
		(grid_size_q > 7'(MAX_GRID)) ? 7'(MAX_GRID) : grid_size_q;
	assign lim_c    = GRID_BITS'(gs_eff_c - 7'd1);

	// room left to the diagonal from each candidate
	assign d_r_c   = lim_q - r_q - c_q - 1'b1;
	assign d_d_c   = d_r_c;
	assign ext_r_c = ({2'b0, d_r_c} < la_m1_q) ? d_r_c : GRID_BITS'(la_m1_q);
	assign ext_d_c = ({2'b0, d_d_c} < la_m1_q) ? d_d_c : GRID_BITS'(la_m1_q);

	assign ram_raddr = (state_q == ST_INIT || state_q == ST_FETCH) ? {r_q, c_q} : score_addr;

	lgp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_GRID * MAX_GRID)) u_grid (
		.clk   (clk),
		.we    (load_c),
		.waddr ({cell_row[GRID_BITS-1:0], cell_col[GRID_BITS-1:0]}),
		.wdata (cell_value[VALUE_BITS-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lgp_score u_score (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_q),
		.rsp     (rsp),
		.rd_addr (score_addr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			grid_size_q   <= 7'd32;
			lookahead_q   <= 7'd8;
			lim_q         <= '0;
			la_m1_q       <= '0;
			r_q           <= '0;
			c_q           <= '0;
			total_q       <= '0;
			right_q       <= '0;
			req_q         <= '0;
			out_valid     <= 1'b0;
			is_step       <= 1'b0;
			step_row      <= '0;
			step_col      <= '0;
			running_total <= '0;
			last          <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			if (out_valid && !out_stall && !emit_c) begin
				out_valid <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_SIZE: grid_size_q <= cfg_data;
					REG_LOOKAHEAD: lookahead_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && opcode == OP_RUN) begin
						lim_q   <= lim_c;
						la_m1_q <= (lookahead_q == '0) ? 7'd0 : lookahead_q - 7'd1;
						r_q     <= '0;
						c_q     <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: state_q <= ST_INIT_ADD;
				ST_INIT_ADD: begin
					total_q <= {{(SUM_BITS - VALUE_BITS){1'b0}}, ram_rdata};
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if ({1'b0, r_q} + {1'b0, c_q} < {1'b0, lim_q}) begin
						req_q.start <= 1'b1;
						req_q.sr    <= r_q;
						req_q.sc    <= c_q + 1'b1;
						req_q.ext   <= ext_r_c;
						req_q.lim   <= lim_q;
						state_q     <= ST_WAIT_R;
					end else begin
						state_q <= ST_EMIT_LAST;
					end
				end
				ST_WAIT_R: begin
					if (rsp.done) begin
						right_q     <= rsp.best;
						req_q.start <= 1'b1;
						req_q.sr    <= r_q + 1'b1;
						req_q.sc    <= c_q;
						req_q.ext   <= ext_d_c;
						state_q     <= ST_WAIT_D;
					end
				end
				ST_WAIT_D: begin
					if (rsp.done) begin
						if (right_q > rsp.best) begin
							c_q <= c_q + 1'b1;
						end else begin
							r_q <= r_q + 1'b1;
						end
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE:  state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_ADD;
				ST_ADD: begin
					total_q <= sat_add(total_q, ram_rdata);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						is_step       <= 1'b1;
						last          <= 1'b0;
						step_row      <= {1'b0, r_q};
						step_col      <= {1'b0, c_q};
						running_total <= total_q;
						state_q       <= ST_CHECK;
					end
				end
				ST_EMIT_LAST: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						is_step       <= 1'b0;
						last          <= 1'b1;
						step_row      <= {1'b0, r_q};
						step_col      <= {1'b0, c_q};
						running_total <= total_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_rsp_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_WAIT_R || state_q == ST_WAIT_D))
		else $error("score result with no request pending");
	a_step_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_step) |-> ({1'b0, step_row} + {1'b0, step_col} <= {2'b0, lim_q}))
		else $error("step beyond bottom diagonal");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last != is_step)) else $error("closing record flags disagree");
endmodule
`default_nettype wire
